// File: design/dual_circular_queue_top_defines.svh
// ----------------------------------------------------------------------------
// dual circular queue assertion macros
// concurrent assertion wrappers included by the queue control (dcq_ctrl)
// ----------------------------------------------------------------------------
`ifndef DUAL_CIRCULAR_QUEUE_TOP_DEFINES_SVH
`define DUAL_CIRCULAR_QUEUE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// property checked at every clock edge outside reset
`define DCQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// property checked at every clock edge, reset included
`define DCQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define DCQ_ASSERT(lbl, prop, msg)
`define DCQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: design/dcq_pkg.sv
// ----------------------------------------------------------------------------
// dcq_pkg
// shared codes and types of the dual circular queue
// ----------------------------------------------------------------------------
package dcq_pkg;

    // payload widths fixed by the interface
    localparam int DATA_W = 32;
    localparam int REQ_W  = 2;
    localparam int CFG_W  = 6;
    localparam int CNT_OUT_W = 6;

    // request codes
    localparam logic [REQ_W-1:0] REQ_ENQ_FIRST  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ENQ_SECOND = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DEQ_FIRST  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_DEQ_SECOND = 2'd3;

    // result status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // per-request outcome handed from the pointer control to the pipeline
    typedef struct packed {
        t_status status;
        logic    dequeue;
    } t_req_info;

endpackage

// File: design/dcq_store.sv
// ----------------------------------------------------------------------------
// dcq_store
// item storage shared by both queues, one write and one registered read port
// ----------------------------------------------------------------------------
module dcq_store #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, data registered and valid in the cycle after the request
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: design/dcq_ctrl.sv
// ----------------------------------------------------------------------------
// dcq_ctrl
// head, tail and occupancy of both rings, request checks and store access
// ----------------------------------------------------------------------------
`include "dual_circular_queue_top_defines.svh"

module dcq_ctrl #(
    parameter int TOTAL_DEPTH = 64,
    parameter int HALF_DEPTH  = 32,
    parameter int PTR_W       = 5,
    parameter int CNT_W       = 6,
    parameter int ADDR_W      = 6
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [dcq_pkg::CFG_W-1:0] i_cfg_cap,
    input  logic                      i_accept,
    input  logic [dcq_pkg::REQ_W-1:0] i_req_type,
    output dcq_pkg::t_req_info        o_info,
    output logic [CNT_W-1:0]          o_first_cnt,
    output logic [CNT_W-1:0]          o_second_cnt,
    output logic                      o_wr_en,
    output logic                      o_rd_en,
    output logic [ADDR_W-1:0]         o_addr
);
    import dcq_pkg::*;

    localparam int CAP_RESET = (HALF_DEPTH < 32) ? HALF_DEPTH : 32;
    localparam int EXT_W     = CNT_W + CFG_W;

    logic [CNT_W-1:0] r_cap;
    logic [PTR_W-1:0] r_first_head;
    logic [PTR_W-1:0] r_first_tail;
    logic [CNT_W-1:0] r_first_occ;
    logic [PTR_W-1:0] r_second_head;
    logic [PTR_W-1:0] r_second_tail;
    logic [CNT_W-1:0] r_second_occ;

    logic [CNT_W-1:0] n_cap;
    logic [PTR_W-1:0] n_first_head;
    logic [PTR_W-1:0] n_first_tail;
    logic [CNT_W-1:0] n_first_occ;
    logic [PTR_W-1:0] n_second_head;
    logic [PTR_W-1:0] n_second_tail;
    logic [CNT_W-1:0] n_second_occ;

    logic             second;
    logic             dequeue;
    logic [CNT_W-1:0] occ_sel;
    logic [PTR_W-1:0] ptr_sel;
    logic [CNT_W:0]   ptr_inc;
    logic [PTR_W-1:0] ptr_next;
    logic [CNT_W-1:0] occ_next;
    logic [EXT_W-1:0] cfg_ext;
    t_status          status;
    logic             commit;

    // decode the request
    always_comb begin
        case (i_req_type)
            REQ_ENQ_FIRST:  begin second = 1'b0; dequeue = 1'b0; end
            REQ_ENQ_SECOND: begin second = 1'b1; dequeue = 1'b0; end
            REQ_DEQ_FIRST:  begin second = 1'b0; dequeue = 1'b1; end
            REQ_DEQ_SECOND: begin second = 1'b1; dequeue = 1'b1; end
            default:        begin second = 1'b0; dequeue = 1'b0; end
        endcase
    end

    // select the addressed ring and check full or empty
    always_comb begin
        occ_sel = second ? r_second_occ : r_first_occ;
        if (dequeue) begin
            ptr_sel = second ? r_second_head : r_first_head;
            status  = (occ_sel == '0) ? ST_EMPTY : ST_DONE;
        end else begin
            ptr_sel = second ? r_second_tail : r_first_tail;
            status  = (occ_sel >= r_cap) ? ST_FULL : ST_DONE;
        end
        commit = i_accept && (status == ST_DONE);
    end

    // pointer advance with wrap at the capacity, occupancy step
    always_comb begin
        ptr_inc  = (CNT_W+1)'(ptr_sel) + (CNT_W+1)'(1);
        ptr_next = (ptr_inc >= (CNT_W+1)'(r_cap)) ? '0 : ptr_inc[PTR_W-1:0];
        occ_next = dequeue ? (occ_sel - CNT_W'(1)) : (occ_sel + CNT_W'(1));
    end

    // clamp the written capacity to between one and one ring half
    always_comb begin
        cfg_ext = {{CNT_W{1'b0}}, i_cfg_cap};
        if (i_cfg_cap == '0) begin
            n_cap = CNT_W'(1);
        end else if (cfg_ext > EXT_W'(HALF_DEPTH)) begin
            n_cap = CNT_W'(HALF_DEPTH);
        end else begin
            n_cap = cfg_ext[CNT_W-1:0];
        end
    end

    // next ring state
    always_comb begin
        n_first_head  = r_first_head;
        n_first_tail  = r_first_tail;
        n_first_occ   = r_first_occ;
        n_second_head = r_second_head;
        n_second_tail = r_second_tail;
        n_second_occ  = r_second_occ;
        if (i_cfg_we) begin
            n_first_head  = '0;
            n_first_tail  = '0;
            n_first_occ   = '0;
            n_second_head = '0;
            n_second_tail = '0;
            n_second_occ  = '0;
        end else if (commit) begin
            if (second) begin
                n_second_occ = occ_next;
                if (dequeue) begin
                    n_second_head = ptr_next;
                end else begin
                    n_second_tail = ptr_next;
                end
            end else begin
                n_first_occ = occ_next;
                if (dequeue) begin
                    n_first_head = ptr_next;
                end else begin
                    n_first_tail = ptr_next;
                end
            end
        end
    end

    // ring state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap         <= CNT_W'(CAP_RESET);
            r_first_head  <= '0;
            r_first_tail  <= '0;
            r_first_occ   <= '0;
            r_second_head <= '0;
            r_second_tail <= '0;
            r_second_occ  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= n_cap;
            end
            r_first_head  <= n_first_head;
            r_first_tail  <= n_first_tail;
            r_first_occ   <= n_first_occ;
            r_second_head <= n_second_head;
            r_second_tail <= n_second_tail;
            r_second_occ  <= n_second_occ;
        end
    end

    // store access and request outcome
    assign o_wr_en      = commit && !dequeue;
    assign o_rd_en      = commit && dequeue;
    assign o_addr       = (second ? ADDR_W'(HALF_DEPTH) : ADDR_W'(0)) + ADDR_W'(ptr_sel);
    assign o_info       = '{status: status, dequeue: dequeue};
    assign o_first_cnt  = n_first_occ;
    assign o_second_cnt = n_second_occ;

    // checks
    `DCQ_ASSERT(a_occ_in_range, (r_first_occ <= r_cap) && (r_second_occ <= r_cap), "occupancy above capacity")
    `DCQ_ASSERT(a_empty_ptrs, ((r_first_occ != '0) || (r_first_head == r_first_tail)) && ((r_second_occ != '0) || (r_second_head == r_second_tail)), "empty ring with head apart from tail")
    `DCQ_ASSERT(a_reject_holds, (i_accept && !i_cfg_we && (status != ST_DONE)) |=> ($stable(r_first_occ) && $stable(r_second_occ)), "rejected request changed occupancy")

endmodule

// File: design/dual_circular_queue_top.sv
// ----------------------------------------------------------------------------
// dual_circular_queue_top
// two circular fifo queues sharing one item store
// ----------------------------------------------------------------------------
// The block takes one request per cycle while o_in_ready is high and returns
// one result per request, in order, through the registered read of the item
// store and then the output register. Enqueues and dequeues each touch a
// single store entry and move a single pointer, so back-to-back requests run
// at one per cycle for as long as results are taken. A full enqueue or an
// empty dequeue returns a status code with zero data and changes nothing.
// Writing the capacity register empties both queues; the user must write it
// only while no request is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module dual_circular_queue_top #(
    parameter int TOTAL_DEPTH = 64,
    parameter int ITEM_WIDTH  = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dcq_pkg::CFG_W-1:0]     i_cfg_half_capacity,
    // requests
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [dcq_pkg::REQ_W-1:0]     i_req_type,
    input  logic signed [dcq_pkg::DATA_W-1:0] i_data_in,
    // results
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [dcq_pkg::DATA_W-1:0] o_data_out,
    output logic [1:0]                    o_status,
    output logic [dcq_pkg::CNT_OUT_W-1:0] o_first_count,
    output logic [dcq_pkg::CNT_OUT_W-1:0] o_second_count
);
    import dcq_pkg::*;

    localparam int HALF_DEPTH = TOTAL_DEPTH / 2;
    localparam int PTR_W      = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
    localparam int CNT_W      = $clog2(HALF_DEPTH + 1);
    localparam int ADDR_W     = $clog2(TOTAL_DEPTH);

    logic                  cfg_we;
    logic                  accept;
    logic                  s1_adv;
    t_req_info             info;
    logic [CNT_W-1:0]      first_cnt;
    logic [CNT_W-1:0]      second_cnt;
    logic                  wr_en;
    logic                  rd_en;
    logic [ADDR_W-1:0]     addr;
    logic [ITEM_WIDTH+DATA_W-1:0] wr_ext;
    logic [ITEM_WIDTH-1:0] rd_data;
    logic [ITEM_WIDTH+DATA_W-1:0] rd_ext;
    logic [CNT_W+CNT_OUT_W-1:0]   first_ext;
    logic [CNT_W+CNT_OUT_W-1:0]   second_ext;

    logic                  r_s1_vld;
    t_req_info             r_s1_info;
    logic [CNT_W-1:0]      r_s1_first;
    logic [CNT_W-1:0]      r_s1_second;
    logic                  r_o_vld;
    logic [DATA_W-1:0]     r_o_data;
    t_status               r_o_status;
    logic [CNT_OUT_W-1:0]  r_o_first;
    logic [CNT_OUT_W-1:0]  r_o_second;

    // handshakes
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;
    assign s1_adv      = r_s1_vld && (!r_o_vld || i_out_ready);
    assign o_in_ready  = !r_s1_vld || s1_adv;
    assign accept      = i_in_valid && o_in_ready;

    // ring pointers and request checks
    dcq_ctrl #(
        .TOTAL_DEPTH (TOTAL_DEPTH),
        .HALF_DEPTH  (HALF_DEPTH),
        .PTR_W       (PTR_W),
        .CNT_W       (CNT_W),
        .ADDR_W      (ADDR_W)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_cap    (i_cfg_half_capacity),
        .i_accept     (accept),
        .i_req_type   (i_req_type),
        .o_info       (info),
        .o_first_cnt  (first_cnt),
        .o_second_cnt (second_cnt),
        .o_wr_en      (wr_en),
        .o_rd_en      (rd_en),
        .o_addr       (addr)
    );

    // item store
    assign wr_ext = {{ITEM_WIDTH{1'b0}}, i_data_in};

    dcq_store #(
        .DEPTH  (TOTAL_DEPTH),
        .WIDTH  (ITEM_WIDTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (addr),
        .i_wr_data (wr_ext[ITEM_WIDTH-1:0]),
        .i_rd_en   (rd_en),
        .i_rd_addr (addr),
        .o_rd_data (rd_data)
    );

    assign rd_ext     = {{DATA_W{1'b0}}, rd_data};
    assign first_ext  = {{CNT_OUT_W{1'b0}}, r_s1_first};
    assign second_ext = {{CNT_OUT_W{1'b0}}, r_s1_second};

    // read stage and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_o_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_o_vld <= 1'b0;
            end
        end
        if (accept) begin
            r_s1_info   <= info;
            r_s1_first  <= first_cnt;
            r_s1_second <= second_cnt;
        end
        if (s1_adv) begin
            r_o_data   <= (r_s1_info.dequeue && (r_s1_info.status == ST_DONE))
                          ? rd_ext[DATA_W-1:0] : '0;
            r_o_status <= r_s1_info.status;
            r_o_first  <= first_ext[CNT_OUT_W-1:0];
            r_o_second <= second_ext[CNT_OUT_W-1:0];
        end
    end

    assign o_out_valid    = r_o_vld;
    assign o_data_out     = r_o_data;
    assign o_status       = r_o_status;
    assign o_first_count  = r_o_first;
    assign o_second_count = r_o_second;

endmodule
